[src/bced_pkg.sv]
package bced_pkg;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned EV_W       = 3;

  localparam logic [CNT_W-1:0] CLICK_MAX    = CNT_W'(15);
  localparam logic [CNT_W-1:0] TRIPLE_COUNT = CNT_W'(3);

  typedef enum logic [EV_W-1:0] {
    EV_NONE   = 3'd0,
    EV_SINGLE = 3'd1,
    EV_DOUBLE = 3'd2,
    EV_TRIPLE = 3'd3,
    EV_MULTI  = 3'd4,
    EV_LONG   = 3'd5,
    EV_REPEAT = 3'd6
  } ev_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE   = 3'd0,
    REG_LONG_PRESS = 3'd1,
    REG_REP_START  = 3'd2,
    REG_MULTI_GAP  = 3'd3,
    REG_REP_IVAL   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] long_press_ms;
    logic [CFG_W-1:0] repeat_start_ms;
    logic [CFG_W-1:0] multi_gap_ms;
    logic [CFG_W-1:0] repeat_interval_ms;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic              key_level;
  } item_t;

endpackage

[src/bced_cfg_regs.sv]
module bced_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bced_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bced_pkg::CFG_W-1:0]     cfg_wdata,
  output bced_pkg::cfg_t                cfg
);
  import bced_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms        <= CFG_W'(20);
      cfg_r.long_press_ms      <= CFG_W'(1000);
      cfg_r.repeat_start_ms    <= CFG_W'(2000);
      cfg_r.multi_gap_ms       <= CFG_W'(300);
      cfg_r.repeat_interval_ms <= CFG_W'(100);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DEBOUNCE:   cfg_r.debounce_ms        <= cfg_wdata;
        REG_LONG_PRESS: cfg_r.long_press_ms      <= cfg_wdata;
        REG_REP_START:  cfg_r.repeat_start_ms    <= cfg_wdata;
        REG_MULTI_GAP:  cfg_r.multi_gap_ms       <= cfg_wdata;
        REG_REP_IVAL:   cfg_r.repeat_interval_ms <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

[src/bced_in_stage.sv]
module bced_in_stage (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [bced_pkg::TIME_W-1:0] in_now_ms,
  input  logic                       in_key_level,
  input  logic                       advance,
  output logic                       s1_valid,
  output bced_pkg::item_t            s1_item
);
  import bced_pkg::*;

  logic  s1_vld_r;
  logic  s1_vld_nxt;
  logic  accept;
  item_t item_r;

  // The stage holds its item only while the core cannot take it.
  assign in_stall = s1_vld_r && !advance;
  assign accept   = in_valid && !in_stall;
  assign s1_valid = s1_vld_r;
  assign s1_item  = item_r;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (accept) begin
      s1_vld_nxt = 1'b1;
    end else if (advance) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.now_ms    <= in_now_ms;
      item_r.key_level <= in_key_level;
    end
  end

endmodule

[src/bced_core.sv]
module bced_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  bced_pkg::cfg_t           cfg,
  input  logic                     s1_valid,
  input  bced_pkg::item_t          s1_item,
  output logic                     advance,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [bced_pkg::EV_W-1:0] out_event_code
);
  import bced_pkg::*;

  typedef enum logic [2:0] {
    ST_INIT     = 3'd0,
    ST_RELEASED = 3'd1,
    ST_PRESSED  = 3'd2,
    ST_LONG     = 3'd3,
    ST_REPEAT   = 3'd4,
    ST_MULTI    = 3'd5
  } state_t;

  state_t            state_r, state_nxt;
  logic [TIME_W-1:0] last_chg_r, last_chg_nxt;
  logic [TIME_W-1:0] last_rep_r, last_rep_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_vld_r, out_vld_nxt;
  ev_t               ev_r, ev_nxt;

  logic [TIME_W-1:0] now;
  logic              key;
  logic [TIME_W-1:0] diff;
  logic [TIME_W-1:0] rep_diff;
  logic              rep_on;
  logic              ge_db, ge_long, ge_rs, ge_gap, rep_ok;

  assign now      = s1_item.now_ms;
  assign key      = s1_item.key_level;
  assign diff     = now - last_chg_r;
  assign rep_diff = now - last_rep_r;
  assign rep_on   = cfg.repeat_start_ms != '0;
  assign ge_db    = diff >= TIME_W'(cfg.debounce_ms);
  assign ge_long  = diff >= TIME_W'(cfg.long_press_ms);
  assign ge_rs    = diff >= TIME_W'(cfg.repeat_start_ms);
  assign ge_gap   = diff >= TIME_W'(cfg.multi_gap_ms);
  assign rep_ok   = rep_diff >= TIME_W'(cfg.repeat_interval_ms);

  // The output register takes a new result whenever it is empty or being drained.
  assign advance        = s1_valid && !(out_vld_r && out_stall);
  assign out_valid      = out_vld_r;
  assign out_event_code = ev_r;

  always_comb begin
    state_nxt    = state_r;
    last_chg_nxt = last_chg_r;
    last_rep_nxt = last_rep_r;
    cnt_nxt      = cnt_r;
    ev_nxt       = EV_NONE;

    unique case (state_r)
      ST_INIT: begin
        state_nxt    = key ? ST_PRESSED : ST_RELEASED;
        last_chg_nxt = now;
      end
      ST_RELEASED: begin
        if (key && ge_db) begin
          state_nxt    = ST_PRESSED;
          last_chg_nxt = now;
        end
      end
      ST_PRESSED: begin
        if (!key) begin
          if (ge_long) begin
            ev_nxt    = EV_LONG;
            state_nxt = ST_RELEASED;
            cnt_nxt   = '0;
          end else begin
            state_nxt = ST_MULTI;
            if (cnt_r < CLICK_MAX) begin
              cnt_nxt = cnt_r + CNT_W'(1);
            end
          end
          last_chg_nxt = now;
        end else if (rep_on && ge_long && !ge_rs) begin
          state_nxt = ST_LONG;
        end else if (rep_on && ge_rs) begin
          state_nxt    = ST_REPEAT;
          last_chg_nxt = now;
          if (rep_ok) begin
            ev_nxt       = EV_REPEAT;
            last_rep_nxt = now;
          end
        end
      end
      ST_LONG: begin
        if (!key) begin
          ev_nxt       = EV_LONG;
          state_nxt    = ST_RELEASED;
          last_chg_nxt = now;
          cnt_nxt      = '0;
        end else if (rep_on && ge_rs) begin
          state_nxt    = ST_REPEAT;
          last_chg_nxt = now;
          if (rep_ok) begin
            ev_nxt       = EV_REPEAT;
            last_rep_nxt = now;
          end
        end
      end
      ST_REPEAT: begin
        if (!key) begin
          state_nxt    = ST_RELEASED;
          last_chg_nxt = now;
          cnt_nxt      = '0;
        end else if (rep_ok) begin
          ev_nxt       = EV_REPEAT;
          last_rep_nxt = now;
        end
      end
      ST_MULTI: begin
        if (key && ge_db) begin
          state_nxt    = ST_PRESSED;
          last_chg_nxt = now;
        end else if (!key && ge_gap) begin
          // A count of zero maps to no event, one to three to their own codes.
          if (cnt_r > TRIPLE_COUNT) begin
            ev_nxt = EV_MULTI;
          end else begin
            ev_nxt = ev_t'(cnt_r[EV_W-1:0]);
          end
          state_nxt    = ST_RELEASED;
          last_chg_nxt = now;
          cnt_nxt      = '0;
        end
      end
      default: begin
        state_nxt    = ST_INIT;
        last_chg_nxt = now;
        cnt_nxt      = '0;
      end
    endcase
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (advance) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_INIT;
      last_chg_r <= '0;
      last_rep_r <= '0;
      cnt_r      <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      if (advance) begin
        state_r    <= state_nxt;
        last_chg_r <= last_chg_nxt;
        last_rep_r <= last_rep_nxt;
        cnt_r      <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ev_r <= ev_nxt;
    end
  end

endmodule

[src/button_click_event_detector.sv]
// Single-key click and long-press detector.
// Input channel: each item is one tick carrying a millisecond timestamp
// (in_now_ms, wrapping) and the raw key level (in_key_level, 1 = pressed).
// Output channel: exactly one item per input item, out_event_code:
// 0 none, 1 single, 2 double, 3 triple, 4 multi, 5 long, 6 long-repeat.
// Configuration: five 16-bit timing registers written through cfg_valid,
// cfg_index and cfg_wdata; cfg_ready is always high. Write them only while
// no item is in flight.
// Each accepted item is held in the input register, and its result is
// registered in the result register; the state update between them is
// combinational. Throughput: one item per cycle while the receiver does
// not stall.
// When the receiver stalls, the result register holds its item, and the
// input register, if empty, still takes one more item before in_stall rises.
// Reset (rst_n low, synchronous) restores the register defaults (20, 1000,
// 2000, 300, 100 ms), returns the key machine to its initial state with
// cleared times and click count, and empties both stages.
module button_click_event_detector (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bced_pkg::TIME_W-1:0]    in_now_ms,
  input  logic                          in_key_level,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bced_pkg::EV_W-1:0]      out_event_code,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bced_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bced_pkg::CFG_W-1:0]     cfg_wdata
);
  import bced_pkg::*;

  cfg_t  cfg;
  item_t s1_item;
  logic  s1_valid;
  logic  advance;

  bced_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bced_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_now_ms    (in_now_ms),
    .in_key_level (in_key_level),
    .advance      (advance),
    .s1_valid     (s1_valid),
    .s1_item      (s1_item)
  );

  bced_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .s1_valid       (s1_valid),
    .s1_item        (s1_item),
    .advance        (advance),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_event_code (out_event_code)
  );

endmodule

[src/bced_checker.sv]
module bced_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [bced_pkg::EV_W-1:0] out_event_code
);
  import bced_pkg::*;

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result still valid after reset");

  // Input backpressure only arises from a full, stalled result register.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output backpressure");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_event_code <= EV_W'(EV_REPEAT)))
    else $error("event code out of range");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_event_code)))
    else $error("stalled result changed");

endmodule

bind button_click_event_detector bced_checker u_bced_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_event_code (out_event_code)
);
